### hw/rtl/ddtsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddtsm_pkg
// Shared constants, register codes and the arctangent table of the rotator.
// ----------------------------------------------------------------------------
package ddtsm_pkg;

	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int ANG_W      = 24;
	localparam int STEPS      = 24;
	localparam int CORDIC_W   = 27;
	localparam int Z_W        = 34;
	localparam int QUOT_W     = 16;

	localparam logic signed [CORDIC_W-1:0] CORDIC_KINV = 27'sd10188014;

	localparam logic [CFG_W-1:0] SPEED_LIMIT_RST = 16'd6554;
	localparam logic [CFG_W-1:0] MIX_RATIO_RST   = 16'd5120;
	localparam logic [CFG_W-1:0] INV_TRACK_RST   = 16'd13653;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPEED_LIMIT,
		CFG_MIX_RATIO,
		CFG_INV_TRACK
	} cfg_idx_t;

	// atan(2^-i) in 2^32 counts per turn
	function automatic logic signed [Z_W-1:0] atan_turn(input int i);
		logic signed [Z_W-1:0] v;
		case (i)
			0: v = 34'sd536870912;
			1: v = 34'sd316933406;
			2: v = 34'sd167458907;
			3: v = 34'sd85004756;
			4: v = 34'sd42667331;
			5: v = 34'sd21354465;
			6: v = 34'sd10679838;
			7: v = 34'sd5340245;
			8: v = 34'sd2670163;
			9: v = 34'sd1335087;
			10: v = 34'sd667544;
			11: v = 34'sd333772;
			12: v = 34'sd166886;
			13: v = 34'sd83443;
			14: v = 34'sd41722;
			15: v = 34'sd20861;
			16: v = 34'sd10430;
			17: v = 34'sd5215;
			18: v = 34'sd2608;
			19: v = 34'sd1304;
			20: v = 34'sd652;
			21: v = 34'sd326;
			22: v = 34'sd163;
			23: v = 34'sd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/ddtsm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddtsm channel interfaces
// Command channel (forward, side, heading) and track result channel.
// ----------------------------------------------------------------------------
interface ddtsm_cmd_if #(parameter int DATA_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] forward_command;
	logic signed [DATA_WIDTH-1:0] side_command;
	logic signed [DATA_WIDTH-1:0] heading_angle;

	modport source(output valid, forward_command, side_command, heading_angle, input ready);
	modport sink(input valid, forward_command, side_command, heading_angle, output ready);
endinterface

interface ddtsm_trk_if #(parameter int DATA_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] left_track_speed;
	logic signed [DATA_WIDTH-1:0] right_track_speed;
	logic signed [DATA_WIDTH-1:0] linear_speed;
	logic signed [23:0]           angular_rate;
	logic                         speed_limited;

	modport source(output valid, left_track_speed, right_track_speed, linear_speed,
		angular_rate, speed_limited, input ready);
	modport sink(input valid, left_track_speed, right_track_speed, linear_speed,
		angular_rate, speed_limited, output ready);
endinterface
`default_nettype wire

### hw/rtl/ddtsm_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddtsm_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module ddtsm_cordic
	import ddtsm_pkg::*;
#(
	parameter int SIDE_W = 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire logic signed [CORDIC_W-1:0] x_in,
	input  wire logic signed [CORDIC_W-1:0] y_in,
	input  wire logic signed [Z_W-1:0]      z_in,
	input  wire logic [SIDE_W-1:0]          side_in,
	output logic                            out_valid,
	output logic signed [CORDIC_W-1:0]      x_out,
	output logic signed [CORDIC_W-1:0]      y_out,
	output logic [SIDE_W-1:0]               side_out
);

	logic signed [CORDIC_W-1:0] x_d [0:STEPS-1];
	logic signed [CORDIC_W-1:0] y_d [0:STEPS-1];
	logic signed [Z_W-1:0]      z_d [0:STEPS-1];
	logic [SIDE_W-1:0]          sd_d [0:STEPS-1];
	logic                       v_d [0:STEPS-1];

	logic signed [CORDIC_W-1:0] x_s [1:STEPS];
	logic signed [CORDIC_W-1:0] y_s [1:STEPS];
	logic signed [Z_W-1:0]      z_s [1:STEPS];
	logic [SIDE_W-1:0]          sd_s [1:STEPS];
	logic                       v_s [1:STEPS];

	assign x_d[0]  = x_in;
	assign y_d[0]  = y_in;
	assign z_d[0]  = z_in;
	assign sd_d[0] = side_in;
	assign v_d[0]  = in_valid;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [Z_W-1:0] AT = atan_turn(i);

		if (i > 0) begin : g_link
			assign x_d[i]  = x_s[i];
			assign y_d[i]  = y_s[i];
			assign z_d[i]  = z_s[i];
			assign sd_d[i] = sd_s[i];
			assign v_d[i]  = v_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_d[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[i+1] <= sd_d[i];
				// rotate toward zero residual angle
				if (!z_d[i][Z_W-1]) begin
					x_s[i+1] <= x_d[i] - (y_d[i] >>> i);
					y_s[i+1] <= y_d[i] + (x_d[i] >>> i);
					z_s[i+1] <= z_d[i] - AT;
				end else begin
					x_s[i+1] <= x_d[i] + (y_d[i] >>> i);
					y_s[i+1] <= y_d[i] - (x_d[i] >>> i);
					z_s[i+1] <= z_d[i] + AT;
				end
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign x_out     = x_s[STEPS];
	assign y_out     = y_s[STEPS];
	assign side_out  = sd_s[STEPS];

endmodule
`default_nettype wire

### hw/rtl/ddtsm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddtsm_div
// Two-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage. Dividend must be below divisor times 2^QUOT_W.
// ----------------------------------------------------------------------------
module ddtsm_div
	import ddtsm_pkg::*;
#(
	parameter int NUM_W  = 44,
	parameter int SIDE_W = 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire logic [NUM_W-1:0]          num_a,
	input  wire logic [NUM_W-1:0]          num_b,
	input  wire logic [NUM_W-QUOT_W-1:0]   den,
	input  wire logic [SIDE_W-1:0]         side_in,
	output logic                           out_valid,
	output logic [QUOT_W-1:0]              quot_a,
	output logic [QUOT_W-1:0]              quot_b,
	output logic [SIDE_W-1:0]              side_out
);

	localparam int DEN_W = NUM_W - QUOT_W;

	logic [NUM_W-1:0]  ra_d [0:QUOT_W-1];
	logic [NUM_W-1:0]  rb_d [0:QUOT_W-1];
	logic [QUOT_W-1:0] qa_d [0:QUOT_W-1];
	logic [QUOT_W-1:0] qb_d [0:QUOT_W-1];
	logic [DEN_W-1:0]  dn_d [0:QUOT_W-1];
	logic [SIDE_W-1:0] sd_d [0:QUOT_W-1];
	logic              v_d  [0:QUOT_W-1];

	logic [NUM_W-1:0]  ra_s [1:QUOT_W];
	logic [NUM_W-1:0]  rb_s [1:QUOT_W];
	logic [QUOT_W-1:0] qa_s [1:QUOT_W];
	logic [QUOT_W-1:0] qb_s [1:QUOT_W];
	logic [DEN_W-1:0]  dn_s [1:QUOT_W];
	logic [SIDE_W-1:0] sd_s [1:QUOT_W];
	logic              v_s  [1:QUOT_W];

	assign ra_d[0] = num_a;
	assign rb_d[0] = num_b;
	assign qa_d[0] = '0;
	assign qb_d[0] = '0;
	assign dn_d[0] = den;
	assign sd_d[0] = side_in;
	assign v_d[0]  = in_valid;

	for (genvar k = 0; k < QUOT_W; k++) begin : g_bit
		localparam int B = QUOT_W - 1 - k;
		logic [NUM_W-1:0] dsh;
		logic             ge_a;
		logic             ge_b;

		if (k > 0) begin : g_link
			assign ra_d[k] = ra_s[k];
			assign rb_d[k] = rb_s[k];
			assign qa_d[k] = qa_s[k];
			assign qb_d[k] = qb_s[k];
			assign dn_d[k] = dn_s[k];
			assign sd_d[k] = sd_s[k];
			assign v_d[k]  = v_s[k];
		end

		assign dsh  = NUM_W'(dn_d[k]) << B;
		assign ge_a = ra_d[k] >= dsh;
		assign ge_b = rb_d[k] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_d[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ra_s[k+1] <= ge_a ? ra_d[k] - dsh : ra_d[k];
				rb_s[k+1] <= ge_b ? rb_d[k] - dsh : rb_d[k];
				qa_s[k+1] <= qa_d[k] | (QUOT_W'(ge_a) << B);
				qb_s[k+1] <= qb_d[k] | (QUOT_W'(ge_b) << B);
				dn_s[k+1] <= dn_d[k];
				sd_s[k+1] <= sd_d[k];
			end
		end
	end

	assign out_valid = v_s[QUOT_W];
	assign quot_a    = qa_s[QUOT_W];
	assign quot_b    = qb_s[QUOT_W];
	assign side_out  = sd_s[QUOT_W];

endmodule
`default_nettype wire

### hw/rtl/diff_drive_track_speed_mixer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_track_speed_mixer_core
// Rotates and mixes forward/side commands into limited track speeds.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries forward_command, side_command and heading_angle; trk returns
//   left/right track speed, linear speed, angular rate and speed_limited,
//   exactly one result beat per command beat, in order.
//   The speed limit, mix ratio and inverse track width registers are written
//   over cfg_we/cfg_index/cfg_data while the pipe is empty.
// Pipeline:
//   a command beat passes the input stage, 24 CORDIC stages, 4 mixing/scaling
//   stages, 16 divider stages, 2 output stages and the output register. A new
//   command is taken every cycle while the pipe is not stalled.
// Reset:
//   arst_n clears all stage valids and loads the register defaults.
// Stall:
//   the whole pipe holds while the output register is full and trk.ready is
//   low; cmd.ready follows that, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module diff_drive_track_speed_mixer_core
	import ddtsm_pkg::*;
#(
	parameter int DATA_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	ddtsm_cmd_if.sink                 cmd,
	ddtsm_trk_if.source               trk
);

	localparam int W      = DATA_WIDTH;
	localparam int SR_W   = W + 5;
	localparam int A_W    = W + 6;
	localparam int P_W    = A_W + CORDIC_W;
	localparam int T_W    = W + 10;
	localparam int V_W    = W + 12;
	localparam int N_W    = V_W + QUOT_W;
	localparam int SIDE_W = 1 + 2 * W + 2 * SR_W;
	localparam int DSD_W  = 1 + 2 * V_W;
	localparam int PA_W   = V_W + 18;
	localparam int AR_W   = PA_W - 13;
	localparam logic signed [W-1:0] QUARTER = W'(1) <<< (W - 2);
	localparam logic signed [Z_W-1:0] ZQ = Z_W'(1) <<< 30;

	logic [CFG_W-1:0] max_q;
	logic [CFG_W-1:0] mix_q;
	logic [CFG_W-1:0] itw_q;
	logic             en;
	logic             out_valid_q;

	// ---------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= SPEED_LIMIT_RST;
			mix_q <= MIX_RATIO_RST;
			itw_q <= INV_TRACK_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SPEED_LIMIT: max_q <= cfg_data;
				CFG_MIX_RATIO: mix_q <= cfg_data;
				CFG_INV_TRACK: itw_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en        = !out_valid_q || trk.ready;
	assign cmd.ready = en;

	// ---------------- stage 1: heading fold, mix ratio products
	logic                   valid_s1;
	logic signed [W-1:0]    f_s1;
	logic signed [W-1:0]    s_s1;
	logic signed [SR_W-1:0] sr_s1;
	logic signed [SR_W-1:0] fr_s1;
	logic                   flip_s1;
	logic signed [Z_W-1:0]  z_s1;

	logic                   flip_c;
	logic signed [W-1:0]    hf_c;
	logic signed [Z_W-1:0]  hz_c;
	logic signed [W+16:0]   ps_c;
	logic signed [W+16:0]   pf_c;

	always_comb begin
		flip_c = (cmd.heading_angle > QUARTER) || (cmd.heading_angle < -QUARTER);
		// a half turn is just the sign bit of a binary angle
		hf_c   = flip_c ? {~cmd.heading_angle[W-1], cmd.heading_angle[W-2:0]}
		                : cmd.heading_angle;
		hz_c   = Z_W'(hf_c);
		ps_c   = cmd.side_command * $signed({1'b0, mix_q});
		pf_c   = cmd.forward_command * $signed({1'b0, mix_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1    <= cmd.forward_command;
			s_s1    <= cmd.side_command;
			sr_s1   <= SR_W'((ps_c + 2048) >>> 12);
			fr_s1   <= SR_W'((pf_c + 2048) >>> 12);
			flip_s1 <= flip_c;
			z_s1    <= hz_c <<< (32 - W);
		end
	end

	// ---------------- CORDIC
	logic                       cv;
	logic signed [CORDIC_W-1:0] cx;
	logic signed [CORDIC_W-1:0] cy;
	logic [SIDE_W-1:0]          cside;

	ddtsm_cordic #(.SIDE_W(SIDE_W)) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s1),
		.x_in     (CORDIC_KINV),
		.y_in     ('0),
		.z_in     (z_s1),
		.side_in  ({flip_s1, f_s1, s_s1, sr_s1, fr_s1}),
		.out_valid(cv),
		.x_out    (cx),
		.y_out    (cy),
		.side_out (cside)
	);

	// ---------------- stage 2: rotate products
	logic                       c_flip;
	logic signed [W-1:0]        c_f;
	logic signed [W-1:0]        c_s;
	logic signed [SR_W-1:0]     c_sr;
	logic signed [SR_W-1:0]     c_fr;
	logic signed [CORDIC_W-1:0] cos_c;
	logic signed [CORDIC_W-1:0] sin_c;
	logic signed [A_W-1:0]      a1_c, b1_c, a2_c, b2_c;

	assign {c_flip, c_f, c_s, c_sr, c_fr} = cside;

	always_comb begin
		cos_c = c_flip ? -cx : cx;
		sin_c = c_flip ? -cy : cy;
		a1_c  = A_W'(c_f) - A_W'(c_sr);
		b1_c  = A_W'(c_s) + A_W'(c_fr);
		a2_c  = A_W'(c_f) + A_W'(c_sr);
		b2_c  = A_W'(c_s) - A_W'(c_fr);
	end

	logic                  valid_s2;
	logic signed [P_W-1:0] p1_s2, p2_s2, p3_s2, p4_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= cv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s2 <= a1_c * cos_c;
			p2_s2 <= b1_c * sin_c;
			p3_s2 <= a2_c * cos_c;
			p4_s2 <= b2_c * sin_c;
		end
	end

	// ---------------- stage 3: track sums back to Q15
	logic signed [P_W:0]   dl_c, dr_c;
	logic                  valid_s3;
	logic signed [T_W-1:0] tl_s3, tr_s3;

	always_comb begin
		dl_c = (P_W+1)'(p1_s2) - (P_W+1)'(p2_s2) + (P_W+1)'(25'sd8388608);
		dr_c = (P_W+1)'(p3_s2) - (P_W+1)'(p4_s2) + (P_W+1)'(25'sd8388608);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tl_s3 <= T_W'(dl_c >>> 24);
			tr_s3 <= T_W'(dr_c >>> 24);
		end
	end

	// ---------------- stage 4: speed limit gain
	logic signed [T_W+16:0] gl_c, gr_c;
	logic                   valid_s4;
	logic signed [V_W-1:0]  vl_s4, vr_s4;

	always_comb begin
		gl_c = tl_s3 * $signed({1'b0, max_q}) + (T_W+17)'(16384);
		gr_c = tr_s3 * $signed({1'b0, max_q}) + (T_W+17)'(16384);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vl_s4 <= V_W'(gl_c >>> 15);
			vr_s4 <= V_W'(gr_c >>> 15);
		end
	end

	// ---------------- stage 5: peak and limit decision
	logic [V_W-1:0] al_c, ar_c, pk_c;
	logic           lim_c;

	always_comb begin
		al_c  = vl_s4[V_W-1] ? V_W'(-vl_s4) : V_W'(vl_s4);
		ar_c  = vr_s4[V_W-1] ? V_W'(-vr_s4) : V_W'(vr_s4);
		pk_c  = (al_c > ar_c) ? al_c : ar_c;
		lim_c = pk_c > V_W'(max_q);
	end

	logic                  valid_s5;
	logic [N_W-1:0]        nl_s5, nr_s5;
	logic [V_W-1:0]        pk_s5;
	logic                  lim_s5;
	logic signed [V_W-1:0] vl_s5, vr_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nl_s5  <= al_c * max_q;
			nr_s5  <= ar_c * max_q;
			pk_s5  <= pk_c;
			lim_s5 <= lim_c;
			vl_s5  <= vl_s4;
			vr_s5  <= vr_s4;
		end
	end

	// ---------------- divider: |v| * max / peak
	logic                  dv;
	logic [QUOT_W-1:0]     ql, qr;
	logic [DSD_W-1:0]      dside;
	logic                  d_lim;
	logic signed [V_W-1:0] d_vl, d_vr;

	ddtsm_div #(.NUM_W(N_W), .SIDE_W(DSD_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s5),
		.num_a    (nl_s5),
		.num_b    (nr_s5),
		.den      (pk_s5),
		.side_in  ({lim_s5, vl_s5, vr_s5}),
		.out_valid(dv),
		.quot_a   (ql),
		.quot_b   (qr),
		.side_out (dside)
	);

	assign {d_lim, d_vl, d_vr} = dside;

	// ---------------- stage 6: pick scaled or raw tracks
	logic                  valid_s6;
	logic signed [V_W-1:0] vl_s6, vr_s6;
	logic                  lim_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= dv;
		end
	end

	// truncating division: quotient of magnitudes takes the dividend sign
	always_ff @(posedge clk) begin
		if (en) begin
			lim_s6 <= d_lim;
			if (d_lim) begin
				vl_s6 <= d_vl[V_W-1] ? -V_W'(ql) : V_W'(ql);
				vr_s6 <= d_vr[V_W-1] ? -V_W'(qr) : V_W'(qr);
			end else begin
				vl_s6 <= d_vl;
				vr_s6 <= d_vr;
			end
		end
	end

	// ---------------- stage 7: round, saturate, angular product
	function automatic logic [W-1:0] sat_w(input logic signed [V_W+1:0] v);
		logic in_rng;
		in_rng = (&v[V_W+1:W-1]) || !(|v[V_W+1:W-1]);
		if (in_rng) begin
			return v[W-1:0];
		end
		return v[V_W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
	endfunction

	logic signed [V_W+1:0] rl_c, rr_c, rm_c;

	always_comb begin
		rl_c = ((V_W+2)'(vl_s6) + (V_W+2)'(1)) >>> 1;
		rr_c = ((V_W+2)'(vr_s6) + (V_W+2)'(1)) >>> 1;
		rm_c = ((V_W+2)'(vl_s6) + (V_W+2)'(vr_s6) + (V_W+2)'(2)) >>> 2;
	end

	logic                   valid_s7;
	logic [W-1:0]           left_s7, right_s7, lin_s7;
	logic signed [PA_W-1:0] pa_s7;
	logic                   lim_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			left_s7  <= sat_w(rl_c);
			right_s7 <= sat_w(rr_c);
			lin_s7   <= sat_w(rm_c);
			pa_s7    <= ((V_W+1)'(vr_s6) - (V_W+1)'(vl_s6)) * $signed({1'b0, itw_q});
			lim_s7   <= lim_s6;
		end
	end

	// ---------------- output register
	logic signed [AR_W-1:0] rate_c;
	logic [ANG_W-1:0]       ang_c;
	logic                   ang_ok;

	always_comb begin
		rate_c = AR_W'((pa_s7 + PA_W'(4096)) >>> 13);
		ang_ok = (&rate_c[AR_W-1:ANG_W-1]) || !(|rate_c[AR_W-1:ANG_W-1]);
		if (ang_ok) begin
			ang_c = rate_c[ANG_W-1:0];
		end else begin
			ang_c = rate_c[AR_W-1] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
		end
	end

	logic [W-1:0]     left_q, right_q, lin_q;
	logic [ANG_W-1:0] ang_q;
	logic             lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			left_q  <= left_s7;
			right_q <= right_s7;
			lin_q   <= lin_s7;
			ang_q   <= ang_c;
			lim_q   <= lim_s7;
		end
	end

	assign trk.valid             = out_valid_q;
	assign trk.left_track_speed  = left_q;
	assign trk.right_track_speed = right_q;
	assign trk.linear_speed      = lin_q;
	assign trk.angular_rate      = ang_q;
	assign trk.speed_limited     = lim_q;

	// ---------------- assertions
	a_ready_follows_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready == (!trk.valid || trk.ready))
		else $error("cmd.ready does not track output stall");

	a_fold_in_quarter: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (z_s1 <= ZQ && z_s1 >= -ZQ))
		else $error("folded heading outside a quarter turn");

	a_quot_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(dv && d_lim) |-> (ql <= max_q && qr <= max_q))
		else $error("scaled track above speed limit");

	a_no_limit_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && lim_s5) |-> (max_q != '0 && pk_s5 > V_W'(max_q)))
		else $error("limit raised without peak above speed limit");

endmodule
`default_nettype wire

### dv/tb_diff_drive_track_speed_mixer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diff_drive_track_speed_mixer_core
// Drives forward/side/heading commands through the mixer under random
// source gaps and sink stalls. Each accepted command goes to a bit-exact
// track speed model, and the results are checked in order. Registers are
// rewritten between phases once the pipe has drained, including the
// extreme settings and a write to the unused index.
// ----------------------------------------------------------------------------
module tb_diff_drive_track_speed_mixer_core;
	import ddtsm_pkg::*;

	localparam int DW = 16;
	localparam int PIPE_DEPTH = 48;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [DW-1:0] left_speed;
		logic signed [DW-1:0] right_speed;
		logic signed [DW-1:0] linear_speed;
		logic signed [23:0]   turn_rate;
		logic                 limited;
	} track_result_t;

	class track_mix_board;
		longint speed_limit, mix_ratio, inv_track;
		track_result_t expected_tracks[$];
		int mismatches;
		int results_seen;
		int limited_seen;

		function new();
			speed_limit = longint'(SPEED_LIMIT_RST);
			mix_ratio = longint'(MIX_RATIO_RST);
			inv_track = longint'(INV_TRACK_RST);
			mismatches = 0;
			results_seen = 0;
			limited_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_SPEED_LIMIT: speed_limit = longint'(val);
				CFG_MIX_RATIO: mix_ratio = longint'(val);
				CFG_INV_TRACK: inv_track = longint'(val);
				default: ;
			endcase
		endfunction

		function longint rnd(longint v, int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function longint clip(longint v, int w);
			longint hi, lo;
			hi = (longint'(1) <<< (w - 1)) - 1;
			lo = -hi - 1;
			return v > hi ? hi : (v < lo ? lo : v);
		endfunction

		function void rotate(longint h, output longint c, output longint s);
			longint x, y, z, dx, dy;
			bit flip;
			flip = 0;
			x = longint'(CORDIC_KINV);
			y = 0;
			if (h > 16384 || h < -16384) begin
				flip = 1;
				h = h > 0 ? h - 32768 : h + 32768;
			end
			z = h * 65536;
			for (int i = 0; i < STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_turn(i);
				end else begin
					x += dx; y -= dy; z += atan_turn(i);
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function void note_command(logic signed [DW-1:0] fwd, logic signed [DW-1:0] side,
			logic signed [DW-1:0] hdg);
			longint f, s, c, sn, sr, fr, tl, tr, vl, vr, al, ar, peak;
			track_result_t r;
			f = longint'(fwd);
			s = longint'(side);
			rotate(longint'(hdg), c, sn);
			sr = rnd(s * mix_ratio, 12);
			fr = rnd(f * mix_ratio, 12);
			tl = rnd((f - sr) * c - (s + fr) * sn, 24);
			tr = rnd((f + sr) * c - (s - fr) * sn, 24);
			vl = rnd(tl * speed_limit, 15);
			vr = rnd(tr * speed_limit, 15);
			al = vl < 0 ? -vl : vl;
			ar = vr < 0 ? -vr : vr;
			peak = al > ar ? al : ar;
			r.limited = 1'b0;
			if (peak > speed_limit) begin
				vl = (vl * speed_limit) / peak;
				vr = (vr * speed_limit) / peak;
				r.limited = 1'b1;
			end
			r.left_speed   = DW'(clip(rnd(vl, 1), DW));
			r.right_speed  = DW'(clip(rnd(vr, 1), DW));
			r.linear_speed = DW'(clip(rnd(vl + vr, 2), DW));
			r.turn_rate    = 24'(clip(rnd((vr - vl) * inv_track, 13), 24));
			expected_tracks.push_back(r);
		endfunction

		function void check_result(track_result_t got);
			track_result_t exp_r;
			results_seen++;
			if (got.limited)
				limited_seen++;
			if (expected_tracks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: left %0d right %0d", got.left_speed,
						got.right_speed);
				return;
			end
			exp_r = expected_tracks.pop_front();
			if (got !== exp_r) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("track mismatch: exp L %0d R %0d lin %0d w %0d lim %0d",
						exp_r.left_speed, exp_r.right_speed, exp_r.linear_speed,
						exp_r.turn_rate, exp_r.limited);
					$display("                got L %0d R %0d lin %0d w %0d lim %0d",
						got.left_speed, got.right_speed, got.linear_speed,
						got.turn_rate, got.limited);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	bit quiet;
	int stall_left;
	int commands_sent;
	int phases_run;
	track_mix_board board;

	ddtsm_cmd_if #(.DATA_WIDTH(DW)) cmd_if();
	ddtsm_trk_if #(.DATA_WIDTH(DW)) trk_if();

	diff_drive_track_speed_mixer_core #(.DATA_WIDTH(DW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd_if.sink),
		.trk(trk_if.source)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("timeout");
		$display("tb_diff_drive_track_speed_mixer_core: errors");
		$finish;
	end

	// beat monitor
	always @(posedge clk) begin
		track_result_t got;
		if (arst_n) begin
			if (cmd_if.valid && cmd_if.ready)
				board.note_command(cmd_if.forward_command, cmd_if.side_command,
					cmd_if.heading_angle);
			if (trk_if.valid && trk_if.ready) begin
				got.left_speed   = trk_if.left_track_speed;
				got.right_speed  = trk_if.right_track_speed;
				got.linear_speed = trk_if.linear_speed;
				got.turn_rate    = trk_if.angular_rate;
				got.limited      = trk_if.speed_limited;
				board.check_result(got);
			end
		end
	end

	// sink stalls
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			trk_if.ready <= 0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 4);
			trk_if.ready <= 0;
		end else begin
			trk_if.ready <= 1;
		end
	end

	task automatic send_command(logic signed [DW-1:0] f, logic signed [DW-1:0] s,
		logic signed [DW-1:0] h);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			cmd_if.valid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		cmd_if.valid <= 1;
		cmd_if.forward_command <= f;
		cmd_if.side_command <= s;
		cmd_if.heading_angle <= h;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		commands_sent++;
	endtask

	task automatic drain_pipe();
		cmd_if.valid <= 0;
		@(posedge clk);
		while (board.expected_tracks.size() > 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		board.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic signed [DW-1:0] pick_command();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return '0;
			3: return $signed(DW'($urandom_range(0, 2047))) - 16'sd1024;
			default: return DW'($urandom);
		endcase
	endfunction

	function automatic logic signed [DW-1:0] pick_heading();
		case ($urandom_range(0, 9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd16385;
			3: return -16'sd16385;
			4: return 16'sh8000;
			default: return DW'($urandom);
		endcase
	endfunction

	task automatic random_commands(int n);
		repeat (n) send_command(pick_command(), pick_command(), pick_heading());
	endtask

	task automatic directed_commands();
		logic signed [DW-1:0] cmd_vals[5];
		logic signed [DW-1:0] hdg_vals[8];
		cmd_vals = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd1, -16'sd1};
		hdg_vals = '{16'sd0, 16'sd16384, -16'sd16384, 16'sd16385, -16'sd16385,
			16'sh8000, 16'sh7fff, 16'sd8192};
		for (int i = 0; i < 20; i++)
			send_command(cmd_vals[i % 5], cmd_vals[(i / 5 + i) % 5], hdg_vals[i % 8]);
	endtask

	initial begin
		board = new();
		quiet = 0;
		stall_left = 0;
		commands_sent = 0;
		phases_run = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_SPEED_LIMIT;
		cfg_data = '0;
		cmd_if.valid = 0;
		cmd_if.forward_command = '0;
		cmd_if.side_command = '0;
		cmd_if.heading_angle = '0;
		trk_if.ready = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset defaults
		directed_commands();
		random_commands(100);
		drain_pipe();

		// zero gain
		write_reg(CFG_SPEED_LIMIT, '0);
		directed_commands();
		random_commands(40);
		drain_pipe();

		// full gain, no mixing, widest turn gain
		write_reg(CFG_SPEED_LIMIT, 16'hffff);
		write_reg(CFG_MIX_RATIO, '0);
		write_reg(CFG_INV_TRACK, 16'hffff);
		directed_commands();
		random_commands(100);
		drain_pipe();

		write_reg(CFG_MIX_RATIO, 16'hffff);
		write_reg(CFG_INV_TRACK, '0);
		random_commands(100);
		drain_pipe();

		// unused index must not disturb anything
		write_reg(CFG_UNUSED, DW'($urandom));
		random_commands(40);
		drain_pipe();

		for (int p = 0; p < 5; p++) begin
			write_reg(CFG_SPEED_LIMIT, CFG_W'($urandom_range(0, 65535)));
			write_reg(CFG_MIX_RATIO, CFG_W'($urandom_range(0, 16384)));
			write_reg(CFG_INV_TRACK, CFG_W'($urandom_range(0, 65535)));
			if (p == 4)
				quiet = 1;
			random_commands(90);
			drain_pipe();
			phases_run++;
		end

		$display("%0d commands, %0d results, %0d speed-limited, across %0d register settings",
			commands_sent, board.results_seen, board.limited_seen, phases_run + 5);
		$display("covered zero and full gain, zero and full mix ratio, heading wraps");
		if (board.mismatches == 0 && board.expected_tracks.size() == 0) begin
			$display("tb_diff_drive_track_speed_mixer_core: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", board.mismatches,
				board.expected_tracks.size());
			$display("tb_diff_drive_track_speed_mixer_core: errors");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/ddtsm_pkg.sv
hw/rtl/ddtsm_if.sv
hw/rtl/ddtsm_cordic.sv
hw/rtl/ddtsm_div.sv
hw/rtl/diff_drive_track_speed_mixer_core.sv
dv/tb_diff_drive_track_speed_mixer_core.sv
